/* hdl/tlvp_pkg.sv */
// Package: types and constants shared by the TLV limit parser.
package tlvp_pkg;

    localparam logic [7:0] TYPE_RATE = 8'hBB;
    localparam logic [7:0] TYPE_OXY  = 8'hCC;
    localparam logic [7:0] RATE_LEN  = 8'd4;
    localparam logic [7:0] OXY_LEN   = 8'd1;

    localparam logic [15:0] RST_RATE_LOW  = 16'd50;
    localparam logic [15:0] RST_RATE_HIGH = 16'd120;
    localparam logic [7:0]  RST_OXY_LOW   = 8'd90;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE_LOW  = 2'd0,
        CFG_RATE_HIGH = 2'd1,
        CFG_OXY_LOW   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2
    } t_phase;

    typedef struct packed {
        logic [15:0] rate_low;
        logic [15:0] rate_high;
        logic [7:0]  oxygen_low;
    } t_limits;

    typedef struct packed {
        logic [15:0] rate_low;
        logic [15:0] rate_high;
        logic [7:0]  oxygen_low;
        logic        rate_updated;
        logic        oxygen_updated;
        logic        cut_short;
    } t_result;

endpackage

/* hdl/tlvp_byte_if.sv */
// Interface: payload byte channel with valid/ready handshake.
interface tlvp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       final_byte;

    modport source (output valid, output payload_byte, output final_byte, input ready);
    modport sink   (input valid, input payload_byte, input final_byte, output ready);
endinterface

/* hdl/tlvp_limit_if.sv */
// Interface: result channel carrying the parsed limits and flags.
interface tlvp_limit_if;
    logic        valid;
    logic        ready;
    logic [15:0] rate_low;
    logic [15:0] rate_high;
    logic [7:0]  oxygen_low;
    logic        rate_updated;
    logic        oxygen_updated;
    logic        cut_short;

    modport source (output valid, output rate_low, output rate_high, output oxygen_low,
                    output rate_updated, output oxygen_updated, output cut_short,
                    input ready);
    modport sink   (input valid, input rate_low, input rate_high, input oxygen_low,
                    input rate_updated, input oxygen_updated, input cut_short,
                    output ready);
endinterface

/* hdl/tlvp_parse.sv */
// Parser: per-byte TLV state update and result formation on the final byte.
module tlvp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  tlvp_pkg::t_limits i_defaults,
    output logic              o_emit,
    output tlvp_pkg::t_result o_result
);
    import tlvp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_left, n_left;
    logic [31:0] r_shift, n_shift;
    t_limits     r_staged, n_staged;
    logic [1:0]  r_marks, n_marks;
    logic        cut;

    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_len    = r_len;
        n_left   = r_left;
        n_shift  = r_shift;
        n_staged = r_staged;
        n_marks  = r_marks;
        cut      = 1'b0;
        unique case (r_phase)
            PH_LEN: begin
                n_len   = i_byte;
                n_left  = i_byte;
                n_shift = '0;
                if (i_byte == 8'd0) begin
                    n_phase = PH_TYPE;
                end else begin
                    n_phase = PH_VALUE;
                    cut     = 1'b1;
                end
            end
            PH_VALUE: begin
                n_shift = {r_shift[23:0], i_byte};
                n_left  = r_left - 8'd1;
                if (n_left == 8'd0) begin
                    n_phase = PH_TYPE;
                    if (r_type == TYPE_RATE && r_len == RATE_LEN) begin
                        n_staged.rate_low  = n_shift[31:16];
                        n_staged.rate_high = n_shift[15:0];
                        n_marks[0]         = 1'b1;
                    end else if (r_type == TYPE_OXY && r_len == OXY_LEN) begin
                        n_staged.oxygen_low = n_shift[7:0];
                        n_marks[1]          = 1'b1;
                    end
                end else begin
                    cut = 1'b1;
                end
            end
            PH_TYPE: begin
                n_type  = i_byte;
                n_phase = PH_LEN;
            end
            default: begin
                n_phase = PH_TYPE;
            end
        endcase

        o_result.rate_low       = n_marks[0] ? n_staged.rate_low : i_defaults.rate_low;
        o_result.rate_high      = n_marks[0] ? n_staged.rate_high : i_defaults.rate_high;
        o_result.oxygen_low     = n_marks[1] ? n_staged.oxygen_low : i_defaults.oxygen_low;
        o_result.rate_updated   = n_marks[0];
        o_result.oxygen_updated = n_marks[1];
        o_result.cut_short      = cut;
        o_emit                  = i_take && i_last;

        // payload end: start the next one clean
        if (i_last) begin
            n_phase = PH_TYPE;
            n_marks = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_marks <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_marks <= n_marks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_type   <= n_type;
            r_len    <= n_len;
            r_left   <= n_left;
            r_shift  <= n_shift;
            r_staged <= n_staged;
        end
    end

endmodule

/* hdl/tlvp_out_stage.sv */
// Output stage: result register that holds a transfer until the receiver takes it.
module tlvp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tlvp_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_free,
    output tlvp_pkg::t_result o_result
);
    import tlvp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* hdl/threshold_tlv_parser_top.sv */
// Top level: TLV alert-limit parser with byte input, result output and config port.
//
// Bytes of a payload arrive on i_in, one transfer each, with final_byte set on
// the last one. Elements are type, length and value bytes. Type 0xBB length 4
// gives rate_low and rate_high (big-endian), type 0xCC length 1 gives
// oxygen_low; anything else is skipped and later elements win.
// One result transfer leaves on o_out for each final byte, in the cycle after it
// is accepted. Limits not given by the payload take the default registers as
// they stand when the final byte is accepted.
// Throughput is one byte per cycle while i_in.ready is high; the parse state is
// updated on each accepted byte and the result register decouples the output side.
// When the receiver stalls with a result pending, i_in.ready drops until the result
// is taken, then input resumes in the same cycle. Defaults are written through
// i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them only while idle, which
// the block does not enforce. Reset (synchronous, active low) returns the defaults
// to 50, 120 and 90, clears the parse state and empties the result register.
module threshold_tlv_parser_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tlvp_byte_if.sink                           i_in,
    tlvp_limit_if.source                        o_out,
    input  logic                                i_cfg_we,
    input  logic [tlvp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tlvp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tlvp_pkg::*;

    t_limits r_defaults;
    logic    take;
    logic    emit;
    logic    free;
    t_result result;
    t_result out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_defaults.rate_low   <= RST_RATE_LOW;
            r_defaults.rate_high  <= RST_RATE_HIGH;
            r_defaults.oxygen_low <= RST_OXY_LOW;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RATE_LOW:  r_defaults.rate_low   <= i_cfg_data;
                CFG_RATE_HIGH: r_defaults.rate_high  <= i_cfg_data;
                CFG_OXY_LOW:   r_defaults.oxygen_low <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = free;
    assign take       = i_in.valid && free;

    tlvp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_byte     (i_in.payload_byte),
        .i_last     (i_in.final_byte),
        .i_defaults (r_defaults),
        .o_emit     (emit),
        .o_result   (result)
    );

    tlvp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (result),
        .i_ready  (o_out.ready),
        .o_valid  (o_out.valid),
        .o_free   (free),
        .o_result (out_result)
    );

    assign o_out.rate_low       = out_result.rate_low;
    assign o_out.rate_high      = out_result.rate_high;
    assign o_out.oxygen_low     = out_result.oxygen_low;
    assign o_out.rate_updated   = out_result.rate_updated;
    assign o_out.oxygen_updated = out_result.oxygen_updated;
    assign o_out.cut_short      = out_result.cut_short;

endmodule
